/* rtl/dsdk_pkg.sv */
// shared types, constants and helpers for the display sleep / dim / key scan block
// no dependencies; used by dsdk_cfg, dsdk_core and display_sleep_dim_keyscan
`default_nettype none

package dsdk_pkg;

   // configuration port geometry
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLEEP_DELAY  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_CURRENT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHADE_ENABLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEYS_ENABLE  = 3'd4;

   // register reset values
   localparam logic [15:0] RST_SLEEP_DELAY  = 16'd500;
   localparam logic [3:0]  RST_BRIGHTNESS   = 4'd15;
   localparam logic [1:0]  RST_PEAK_CURRENT = 2'd0;
   localparam logic        RST_SHADE_ENABLE = 1'b0;
   localparam logic        RST_KEYS_ENABLE  = 1'b1;

   // command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_WAKE = 1'b1;

   // timer periods
   localparam logic [4:0] PERIOD_NORMAL  = 5'd20;
   localparam logic [4:0] PERIOD_SHADE_A = 5'd5;
   localparam logic [4:0] PERIOD_SHADE_B = 5'd10;

   localparam logic [6:0]  CTRL_ON     = 7'h40;
   localparam logic [6:0]  CTRL_OFF    = 7'h00;
   localparam logic [15:0] IDLE_MAX    = 16'hFFFF;
   localparam int          KEYS_W      = 4;
   localparam int          DEFAULT_NUM_KEYS = 4;

   typedef struct packed {
      logic [15:0] sleep_delay;
      logic [3:0]  brightness;
      logic [1:0]  peak_current;
      logic        shade_enable;
      logic        keys_enable;
   } cfg_type;

   typedef struct packed {
      logic              command;
      logic [KEYS_W-1:0] buttons;
   } req_type;

   typedef struct packed {
      logic              ctrl_valid;
      logic [6:0]        ctrl_word;
      logic [KEYS_W-1:0] key_events;
      logic              refresh;
      logic              shaded_frame;
      logic [4:0]        timer_period;
      logic              running;
   } rsp_type;

   // control word: on bit, peak current in 5:4, pwm level in 3:0
   function automatic logic [6:0] make_word(input logic [1:0] peak, input logic [3:0] pwm);
      return CTRL_ON | {1'b0, peak, pwm};
   endfunction

endpackage

`default_nettype wire

/* rtl/dsdk_cfg.sv */
// configuration register file of the display sleep / dim / key scan block
// depends on dsdk_pkg
`default_nettype none

module dsdk_cfg (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [dsdk_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [dsdk_pkg::CSR_DATA_W-1:0] csr_wdata,
   output dsdk_pkg::cfg_type                   cfg
);

   dsdk_pkg::cfg_type cfg_ff;
   dsdk_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            dsdk_pkg::CSR_SLEEP_DELAY:  cfg_in.sleep_delay  = csr_wdata;
            dsdk_pkg::CSR_BRIGHTNESS:   cfg_in.brightness   = csr_wdata[3:0];
            dsdk_pkg::CSR_PEAK_CURRENT: cfg_in.peak_current = csr_wdata[1:0];
            dsdk_pkg::CSR_SHADE_ENABLE: cfg_in.shade_enable = csr_wdata[0];
            dsdk_pkg::CSR_KEYS_ENABLE:  cfg_in.keys_enable  = csr_wdata[0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sleep_delay  <= dsdk_pkg::RST_SLEEP_DELAY;
         cfg_ff.brightness   <= dsdk_pkg::RST_BRIGHTNESS;
         cfg_ff.peak_current <= dsdk_pkg::RST_PEAK_CURRENT;
         cfg_ff.shade_enable <= dsdk_pkg::RST_SHADE_ENABLE;
         cfg_ff.keys_enable  <= dsdk_pkg::RST_KEYS_ENABLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/dsdk_core.sv */
// sleep / dim sequencer, key edge scan and shade phase state with its update logic
// depends on dsdk_pkg
`default_nettype none

module dsdk_core #(
   parameter int NUM_KEYS = dsdk_pkg::DEFAULT_NUM_KEYS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire dsdk_pkg::req_type item,
   input  wire dsdk_pkg::cfg_type cfg,
   output dsdk_pkg::rsp_type      result
);

   localparam int ScanKeys = (NUM_KEYS > dsdk_pkg::KEYS_W) ? dsdk_pkg::KEYS_W : NUM_KEYS;
   localparam logic [dsdk_pkg::KEYS_W-1:0] KeyMask =
      dsdk_pkg::KEYS_W'((1 << ScanKeys) - 1);

   logic [15:0]                 idle_ff, idle_in;
   logic                        asleep_ff, asleep_in;
   logic [3:0]                  dim_ff, dim_in;
   logic                        running_ff, running_in;
   logic                        phase_ff, phase_in;
   logic [dsdk_pkg::KEYS_W-1:0] held_ff, held_in;
   logic [4:0]                  period_ff, period_in;

   logic [dsdk_pkg::KEYS_W-1:0] btn;

   always_comb begin
      btn        = item.buttons & KeyMask;
      idle_in    = idle_ff;
      asleep_in  = asleep_ff;
      dim_in     = dim_ff;
      running_in = running_ff;
      phase_in   = phase_ff;
      held_in    = held_ff;
      period_in  = period_ff;

      result.ctrl_valid   = 1'b0;
      result.ctrl_word    = dsdk_pkg::CTRL_OFF;
      result.key_events   = '0;
      result.refresh      = 1'b0;
      result.shaded_frame = 1'b0;

      if (item.command == dsdk_pkg::CMD_WAKE) begin
         idle_in = '0;
         if (asleep_ff) begin
            result.ctrl_valid = 1'b1;
            result.ctrl_word  = dsdk_pkg::make_word(cfg.peak_current, cfg.brightness);
            asleep_in  = 1'b0;
            period_in  = dsdk_pkg::PERIOD_NORMAL;
            running_in = 1'b1;
            held_in    = held_ff | btn;
         end
      end else if (running_ff) begin
         // sleep entry and dimming steps
         if (idle_ff > cfg.sleep_delay) begin
            if (!asleep_ff) begin
               asleep_in = 1'b1;
               dim_in    = cfg.brightness;
            end else if (idle_ff[1:0] == 2'd0) begin
               result.ctrl_valid = 1'b1;
               if (dim_ff != 4'd0) begin
                  result.ctrl_word = dsdk_pkg::make_word(cfg.peak_current, dim_ff);
                  dim_in = dim_ff - 4'd1;
               end else begin
                  result.ctrl_word = dsdk_pkg::CTRL_OFF;
                  running_in = 1'b0;
               end
            end
         end
         if (idle_ff != dsdk_pkg::IDLE_MAX) begin
            idle_in = idle_ff + 16'd1;
         end

         // frame refresh, key scan on normal-phase ticks
         result.refresh = 1'b1;
         if (!phase_ff) begin
            if (cfg.keys_enable) begin
               result.key_events = btn & ~held_ff;
            end
            held_in   = btn;
            phase_in  = cfg.shade_enable;
            period_in = cfg.shade_enable ? dsdk_pkg::PERIOD_SHADE_A : dsdk_pkg::PERIOD_NORMAL;
         end else begin
            phase_in  = 1'b0;
            period_in = cfg.shade_enable ? dsdk_pkg::PERIOD_SHADE_B : dsdk_pkg::PERIOD_NORMAL;
            result.shaded_frame = cfg.shade_enable;
         end
      end

      result.timer_period = period_in;
      result.running      = running_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff    <= '0;
         asleep_ff  <= 1'b0;
         dim_ff     <= '0;
         running_ff <= 1'b1;
         phase_ff   <= 1'b0;
         held_ff    <= '0;
         period_ff  <= dsdk_pkg::PERIOD_NORMAL;
      end else if (fire) begin
         idle_ff    <= idle_in;
         asleep_ff  <= asleep_in;
         dim_ff     <= dim_in;
         running_ff <= running_in;
         phase_ff   <= phase_in;
         held_ff    <= held_in;
         period_ff  <= period_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/display_sleep_dim_keyscan.sv */
// top level of the display sleep / dim / key scan block: channel registers and hookup
// depends on dsdk_pkg, dsdk_cfg and dsdk_core
//
// Each request transaction is a timer tick or a wake event with the current
// button levels; each one yields exactly one response transaction carrying
// the display control word (if any), newly pressed keys, the refresh and
// shade flags, the next timer period and the running flag. Throughput is one
// transaction per cycle: a request lands in the input register, the state
// update runs in one short combinational pass between that register and the
// response register, which holds the response until the response channel
// takes it. Only a stalled response channel slows the input. Configuration
// writes take effect at the next edge and are meant to happen while no
// transaction is in flight.
`default_nettype none

module display_sleep_dim_keyscan #(
   parameter int NUM_KEYS = dsdk_pkg::DEFAULT_NUM_KEYS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire dsdk_pkg::req_type               req_data,

   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output dsdk_pkg::rsp_type                    rsp_data,

   // configuration write port
   input  wire logic                            csr_we,
   input  wire logic [dsdk_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [dsdk_pkg::CSR_DATA_W-1:0] csr_wdata
);

   dsdk_pkg::cfg_type cfg;

   // input register
   logic              in_valid_ff, in_valid_in;
   dsdk_pkg::req_type in_data_ff;

   // response register
   logic              out_valid_ff, out_valid_in;
   dsdk_pkg::rsp_type out_data_ff;

   dsdk_pkg::rsp_type result;

   logic out_load;   // response register free or being drained
   logic fire;       // held request moves through the update this cycle
   logic accept;     // new request transaction taken

   assign out_load  = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_load;
   assign req_ready = !in_valid_ff || fire;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= result;
      end
   end

   dsdk_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // state only advances when the held request is consumed
   dsdk_core #(
      .NUM_KEYS (NUM_KEYS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for display_sleep_dim_keyscan: directed cases, then randomized traffic
// depends on dsdk_pkg and the display_sleep_dim_keyscan rtl, nothing else
// checks every response transaction against an in-bench prediction of the sleep/dim/key logic
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_KEYS    = 4;
   // only the low NUM_KEYS buttons are scanned
   localparam logic [dsdk_pkg::KEYS_W-1:0] SCAN_MASK =
      dsdk_pkg::KEYS_W'((1 << NUM_KEYS) - 1);
   // cycles without any accepted transaction before the run is declared hung
   localparam int STUCK_LIMIT = 4000;
   // extra settling wait after every expected response has come back
   localparam int DRAIN_CYCLES = 6;
   localparam int LONG_STALL   = 300;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   dsdk_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   dsdk_pkg::rsp_type rsp_data;
   logic              csr_we;
   logic [dsdk_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [dsdk_pkg::CSR_DATA_W-1:0] csr_wdata;

   display_sleep_dim_keyscan #(
      .NUM_KEYS (NUM_KEYS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // shared bench state
   // ---------------------------------------------------------------------
   int      error_count      = 0;
   int      send_idle_pct    = 0;   // chance per cycle that the sender holds back
   int      recv_stall_pct   = 0;   // chance per cycle that the receiver drops ready
   int      stall_cycles_req = 0;   // one-shot request for a long receiver hold-off
   int      stuck_cycles     = 0;
   logic [dsdk_pkg::KEYS_W-1:0] last_buttons = '0;

   // responses predicted for accepted requests, oldest first
   dsdk_pkg::rsp_type display_expect_q[$];

   // mirror of the configuration registers
   dsdk_pkg::cfg_type shadow_cfg;

   // mirror of the block state
   logic [15:0]                 idle_ticks;
   logic                        sleeping;
   logic [3:0]                  dim_pwm;
   logic                        ticking;
   logic                        shade_odd;
   logic [dsdk_pkg::KEYS_W-1:0] held_keys;
   logic [4:0]                  next_period;

   // ---------------------------------------------------------------------
   // clock
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // prediction of the sleep / dim / key scan behavior
   // ---------------------------------------------------------------------
   task automatic reset_display_state();
      shadow_cfg.sleep_delay  = dsdk_pkg::RST_SLEEP_DELAY;
      shadow_cfg.brightness   = dsdk_pkg::RST_BRIGHTNESS;
      shadow_cfg.peak_current = dsdk_pkg::RST_PEAK_CURRENT;
      shadow_cfg.shade_enable = dsdk_pkg::RST_SHADE_ENABLE;
      shadow_cfg.keys_enable  = dsdk_pkg::RST_KEYS_ENABLE;
      idle_ticks  = '0;
      sleeping    = 1'b0;
      dim_pwm     = '0;
      ticking     = 1'b1;
      shade_odd   = 1'b0;
      held_keys   = '0;
      next_period = dsdk_pkg::PERIOD_NORMAL;
   endtask

   // display-on word: on bit, peak current select, pwm level
   function automatic logic [6:0] pwm_word(input logic [3:0] pwm);
      return dsdk_pkg::CTRL_ON | {1'b0, shadow_cfg.peak_current, pwm};
   endfunction

   function automatic dsdk_pkg::rsp_type predict_display(input dsdk_pkg::req_type item);
      dsdk_pkg::rsp_type           r;
      logic [dsdk_pkg::KEYS_W-1:0] pressed;
      r       = '0;
      pressed = item.buttons & SCAN_MASK;
      if (item.command == dsdk_pkg::CMD_WAKE) begin
         idle_ticks = '0;
         // only a sleeping display is restored; awake it just clears the count
         if (sleeping) begin
            r.ctrl_valid = 1'b1;
            r.ctrl_word  = pwm_word(shadow_cfg.brightness);
            sleeping     = 1'b0;
            next_period  = dsdk_pkg::PERIOD_NORMAL;
            ticking      = 1'b1;
            held_keys    = held_keys | pressed;
         end
      end else if (ticking) begin
         if (idle_ticks > shadow_cfg.sleep_delay) begin
            if (!sleeping) begin
               sleeping = 1'b1;
               dim_pwm  = shadow_cfg.brightness;
            end else if (idle_ticks[1:0] == 2'b00) begin
               // one dim step every fourth count, display off once the level reaches zero
               r.ctrl_valid = 1'b1;
               if (dim_pwm != '0) begin
                  r.ctrl_word = pwm_word(dim_pwm);
                  dim_pwm     = dim_pwm - 4'd1;
               end else begin
                  r.ctrl_word = dsdk_pkg::CTRL_OFF;
                  ticking     = 1'b0;
               end
            end
         end
         if (idle_ticks != dsdk_pkg::IDLE_MAX) idle_ticks = idle_ticks + 16'd1;

         r.refresh = 1'b1;
         if (!shade_odd) begin
            // normal frame: scan for rising key edges
            if (shadow_cfg.keys_enable) r.key_events = pressed & ~held_keys;
            held_keys = pressed;
            if (shadow_cfg.shade_enable) begin
               shade_odd   = 1'b1;
               next_period = dsdk_pkg::PERIOD_SHADE_A;
            end else begin
               next_period = dsdk_pkg::PERIOD_NORMAL;
            end
         end else begin
            // shaded phase: no key scan; falls back to normal if shading was turned off
            shade_odd = 1'b0;
            if (shadow_cfg.shade_enable) begin
               next_period    = dsdk_pkg::PERIOD_SHADE_B;
               r.shaded_frame = 1'b1;
            end else begin
               next_period = dsdk_pkg::PERIOD_NORMAL;
            end
         end
      end
      r.timer_period = next_period;
      r.running      = ticking;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // request side: one transaction per call, valid held until accepted
   // ---------------------------------------------------------------------
   task automatic send_request(input logic cmd, input logic [dsdk_pkg::KEYS_W-1:0] buttons);
      dsdk_pkg::req_type item;
      item.command = cmd;
      item.buttons = buttons;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      display_expect_q.push_back(predict_display(item));
   endtask

   // drop valid and let every outstanding response come back
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (display_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // configuration writes, only issued with nothing in flight
   // ---------------------------------------------------------------------
   task automatic put_reg(input logic [dsdk_pkg::CSR_IDX_W-1:0]  idx,
                          input logic [dsdk_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic apply_config(input dsdk_pkg::cfg_type c);
      shadow_cfg = c;
      put_reg(dsdk_pkg::CSR_SLEEP_DELAY,  c.sleep_delay);
      put_reg(dsdk_pkg::CSR_BRIGHTNESS,   dsdk_pkg::CSR_DATA_W'(c.brightness));
      put_reg(dsdk_pkg::CSR_PEAK_CURRENT, dsdk_pkg::CSR_DATA_W'(c.peak_current));
      put_reg(dsdk_pkg::CSR_SHADE_ENABLE, dsdk_pkg::CSR_DATA_W'(c.shade_enable));
      put_reg(dsdk_pkg::CSR_KEYS_ENABLE,  dsdk_pkg::CSR_DATA_W'(c.keys_enable));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic dsdk_pkg::cfg_type make_cfg(input logic [15:0] delay,
                                                  input logic [3:0] bright,
                                                  input logic [1:0] peak, input logic shade,
                                                  input logic keys);
      dsdk_pkg::cfg_type c;
      c.sleep_delay  = delay;
      c.brightness   = bright;
      c.peak_current = peak;
      c.shade_enable = shade;
      c.keys_enable  = keys;
      return c;
   endfunction

   // short delays dominate so that sleep and dim-out are reached often
   function automatic dsdk_pkg::cfg_type random_cfg();
      logic [15:0] delay;
      case ($urandom_range(0, 9))
         0:       delay = 16'd0;
         1:       delay = 16'd60000;
         2, 3:    delay = 16'($urandom_range(9, 40));
         default: delay = 16'($urandom_range(0, 8));
      endcase
      return make_cfg(delay, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endfunction

   // buttons mostly held, sometimes one toggles, sometimes a fresh random set
   function automatic logic [dsdk_pkg::KEYS_W-1:0] next_buttons(
      input logic [dsdk_pkg::KEYS_W-1:0] prev);
      case ($urandom_range(0, 3))
         0, 1:    return prev;
         2:       return prev ^ dsdk_pkg::KEYS_W'(1 << $urandom_range(0, dsdk_pkg::KEYS_W - 1));
         default: return dsdk_pkg::KEYS_W'($urandom_range(0, 15));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // response side: ready with random stalls, plus a one-shot long hold-off
   // ---------------------------------------------------------------------
   initial begin : rsp_side
      int hold;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_cycles_req != 0) begin
            hold             = stall_cycles_req;
            stall_cycles_req = 0;
            rsp_ready       <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // response checking, field by field against the oldest prediction
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      dsdk_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (display_expect_q.size() == 0) begin
            $error("response transaction with nothing expected");
            error_count++;
         end else begin
            want = display_expect_q.pop_front();
            check_field("ctrl_valid",   16'(want.ctrl_valid),   16'(rsp_data.ctrl_valid));
            check_field("ctrl_word",    16'(want.ctrl_word),    16'(rsp_data.ctrl_word));
            check_field("key_events",   16'(want.key_events),   16'(rsp_data.key_events));
            check_field("refresh",      16'(want.refresh),      16'(rsp_data.refresh));
            check_field("shaded_frame", 16'(want.shaded_frame), 16'(rsp_data.shaded_frame));
            check_field("timer_period", 16'(want.timer_period), 16'(rsp_data.timer_period));
            check_field("running",      16'(want.running),      16'(rsp_data.running));
         end
      end
   end

   // watchdog: a run that stops moving transactions is hung
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset configuration: key edges and a wake while awake
   task automatic test_basic_keys();
      send_request(dsdk_pkg::CMD_TICK, 4'h0);
      send_request(dsdk_pkg::CMD_TICK, 4'hF);   // all four keys rise at once
      send_request(dsdk_pkg::CMD_TICK, 4'hF);   // held, no new events
      send_request(dsdk_pkg::CMD_TICK, 4'h5);
      send_request(dsdk_pkg::CMD_TICK, 4'h0);
      send_request(dsdk_pkg::CMD_TICK, 4'hA);
      send_request(dsdk_pkg::CMD_WAKE, 4'h5);   // awake: only clears the count
   endtask

   // no delay, lowest nonzero brightness, keys off: full dim-out then stopped ticks
   task automatic test_dim_out();
      int guard;
      wait_for_results();
      apply_config(make_cfg(16'd0, 4'd1, 2'd3, 1'b0, 1'b0));
      guard = 0;
      while (ticking && guard < 40) begin
         send_request(dsdk_pkg::CMD_TICK, dsdk_pkg::KEYS_W'($urandom_range(0, 15)));
         guard++;
      end
      send_request(dsdk_pkg::CMD_TICK, 4'hF);   // stopped: ignored
      send_request(dsdk_pkg::CMD_WAKE, 4'hF);   // restores brightness, marks held keys
      send_request(dsdk_pkg::CMD_TICK, 4'hF);
   endtask

   // wake arriving after the first dim step
   task automatic test_wake_during_dim();
      int guard;
      wait_for_results();
      apply_config(make_cfg(16'd2, 4'd15, 2'd1, 1'b1, 1'b1));
      send_request(dsdk_pkg::CMD_WAKE, 4'h0);
      guard = 0;
      while (!(sleeping && dim_pwm != shadow_cfg.brightness) && guard < 20) begin
         send_request(dsdk_pkg::CMD_TICK, 4'h1);
         guard++;
      end
      send_request(dsdk_pkg::CMD_WAKE, 4'h6);
      send_request(dsdk_pkg::CMD_TICK, 4'hE);
   endtask

   // shading switched off while in the shaded phase
   task automatic test_shade_cancel();
      dsdk_pkg::cfg_type c;
      wait_for_results();
      c = make_cfg(16'd500, 4'd8, 2'd2, 1'b1, 1'b1);
      apply_config(c);
      send_request(dsdk_pkg::CMD_WAKE, 4'h0);
      send_request(dsdk_pkg::CMD_TICK, 4'h0);
      if (!shade_odd) send_request(dsdk_pkg::CMD_TICK, 4'h0);
      wait_for_results();
      c.shade_enable = 1'b0;
      apply_config(c);
      send_request(dsdk_pkg::CMD_TICK, 4'hF);   // normal frame, no scan
      send_request(dsdk_pkg::CMD_TICK, 4'hF);   // scan resumes
   endtask

   // largest delay: the count only climbs, the display never starts to dim
   task automatic test_count_saturation();
      int i;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wait_for_results();
      apply_config(make_cfg(16'hFFFF, 4'd15, 2'd2, 1'b1, 1'b1));
      send_request(dsdk_pkg::CMD_WAKE, 4'h0);
      for (i = 0; i < 40; i++) begin
         last_buttons = next_buttons(last_buttons);
         send_request(dsdk_pkg::CMD_TICK, last_buttons);
      end
      send_request(dsdk_pkg::CMD_WAKE, 4'h8);
      send_request(dsdk_pkg::CMD_TICK, 4'h8);
      wait_for_results();
   endtask

   // long receiver hold-off fills the pipe, then the sender waits for a full drain
   task automatic test_backpressure();
      int i;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wait_for_results();
      apply_config(make_cfg(16'd3, 4'd4, 2'd1, 1'b1, 1'b1));
      stall_cycles_req = LONG_STALL;
      for (i = 0; i < 40; i++) begin
         last_buttons = next_buttons(last_buttons);
         send_request(($urandom_range(0, 19) == 0) ? dsdk_pkg::CMD_WAKE : dsdk_pkg::CMD_TICK,
                      last_buttons);
      end
      wait_for_results();
      for (i = 0; i < 20; i++) begin
         last_buttons = next_buttons(last_buttons);
         send_request(dsdk_pkg::CMD_TICK, last_buttons);
      end
      wait_for_results();
   endtask

   // mostly tick runs with random buttons, occasional wakes; reconfigured every so often
   task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct,
                                      input logic fixed_extreme);
      int   counted;
      int   since_cfg;
      logic cmd;
      counted        = 0;
      since_cfg      = 0;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      wait_for_results();
      if (fixed_extreme) apply_config(make_cfg(16'd0, 4'd15, 2'd3, 1'b1, 1'b1));
      else apply_config(random_cfg());
      while (counted < items) begin
         if (since_cfg >= 120) begin
            wait_for_results();
            apply_config(random_cfg());
            since_cfg = 0;
         end
         // once stopped, wakes come quickly; a few stopped ticks stay in as noise
         if (!ticking) begin
            cmd = ($urandom_range(0, 99) < 60) ? dsdk_pkg::CMD_WAKE : dsdk_pkg::CMD_TICK;
         end else begin
            cmd = ($urandom_range(0, 99) < 3) ? dsdk_pkg::CMD_WAKE : dsdk_pkg::CMD_TICK;
         end
         if (cmd == dsdk_pkg::CMD_WAKE || ticking) begin
            counted++;
            since_cfg++;
         end
         last_buttons = next_buttons(last_buttons);
         send_request(cmd, last_buttons);
      end
      wait_for_results();
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset_display_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_keys();
      test_dim_out();
      test_wake_during_dim();
      test_shade_cancel();
      test_count_saturation();
      test_backpressure();
      test_random_traffic(430, 0,  0,  1'b1);
      test_random_traffic(430, 78, 0,  1'b0);
      test_random_traffic(430, 0,  78, 1'b0);
      test_random_traffic(430, 24, 24, 1'b0);

      wait_for_results();
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
rtl/dsdk_pkg.sv
rtl/dsdk_cfg.sv
rtl/dsdk_core.sv
rtl/display_sleep_dim_keyscan.sv
tb/testbench.sv
